FILE: rtl/core/message_ring_buffer_unit_assert.svh
// Assertion macros for the message ring buffer unit.
`ifndef MESSAGE_RING_BUFFER_UNIT_ASSERT_SVH
`define MESSAGE_RING_BUFFER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge of clk outside reset.
`define MRB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("message ring buffer check failed");
// Implication whose consequent is checked in the following cycle.
`define MRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("message ring buffer check failed");
`else
`define MRB_ASSERT_IMPL(label, ante, cons)
`define MRB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/core/mrb_pkg.sv
// Shared types and constants of the message ring buffer unit.
package mrb_pkg;

    localparam int SLOTS     = 4;
    localparam int MSG_BYTES = 64;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_W     = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
    localparam int ADDR_W    = SLOT_W + IDX_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int CNT_W  = 3;
    localparam int STAT_W = 3;
    localparam int CFG_W  = 7;
    localparam int REG_W  = 1;

    localparam logic [REG_W-1:0] REG_SLOT_COUNT  = 1'd0;
    localparam logic [REG_W-1:0] REG_BYTES_LIMIT = 1'd1;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd2;
    localparam logic [STAT_W-1:0] ST_SMALL = 3'd3;
    localparam logic [STAT_W-1:0] ST_LONG  = 3'd4;

    typedef enum logic {
        CMD_PUT,
        CMD_GET
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [BYTE_W-1:0]  data;
        logic               last;
        logic [LEN_W-1:0]   room;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic {
        BK_IDLE,
        BK_STREAM
    } back_state_t;

    typedef struct packed {
        logic streaming;
    } back_status_t;

    typedef enum logic [1:0] {
        DROP_NONE,
        DROP_FULL,
        DROP_LONG
    } drop_t;

endpackage

FILE: rtl/core/mrb_front.sv
// Front end: accepts input beats, classifies them into commands and feeds the queue.
module mrb_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [7:0]                    put_byte,
    input  logic                          put_last,
    input  logic [6:0]                    get_room,
    input  mrb_pkg::q_status_t            q_stat,
    output logic                          q_push,
    output mrb_pkg::cmd_t                 q_push_cmd
);
    import mrb_pkg::*;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_class;
    logic accept;

    // A put keeps its byte and last mark, a get keeps only its room.
    always_comb
    begin
        cmd_class = '0;
        if (action)
        begin
            cmd_class.kind = CMD_GET;
            cmd_class.room = get_room;
        end
        else
        begin
            cmd_class.kind = CMD_PUT;
            cmd_class.data = put_byte;
            cmd_class.last = put_last;
        end
    end

    assign q_push     = valid_reg && !q_stat.full;
    assign in_stall   = valid_reg && q_stat.full;
    assign accept     = in_valid && !in_stall;
    assign q_push_cmd = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_class;
        end
    end

endmodule

FILE: rtl/core/mrb_queue.sv
// Two-entry command queue between the front end and the back end.
module mrb_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mrb_pkg::cmd_t         push_cmd,
    input  logic                  pop,
    output mrb_pkg::cmd_t         head_cmd,
    output mrb_pkg::q_status_t    stat
);
    import mrb_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/core/mrb_back.sv
// Back end: slot bookkeeping, message memory, get streaming and the result register.
module mrb_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_addr,
    input  logic [6:0]            cfg_wdata,
    input  mrb_pkg::q_status_t    q_stat,
    input  mrb_pkg::cmd_t         head_cmd,
    output logic                  q_pop,
    output mrb_pkg::back_status_t bk_stat,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            status,
    output logic [7:0]            out_byte,
    output logic                  out_last,
    output logic [6:0]            msg_length
);
    import mrb_pkg::*;

    back_state_t        state_reg, state_next;
    logic [SLOT_W-1:0]  write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0]  read_slot_reg, read_slot_next;
    logic [LEN_W-1:0]   put_count_reg, put_count_next;
    drop_t              drop_reg, drop_next;
    logic               occ_reg [SLOTS];
    logic               occ_next [SLOTS];
    logic [LEN_W-1:0]   slot_len_reg [SLOTS];
    logic               len_we;
    logic [CNT_W-1:0]   cfg_count_reg;
    logic [CFG_W-1:0]   cfg_limit_reg;
    logic [SLOT_W-1:0]  strm_slot_reg, strm_slot_next;
    logic [LEN_W-1:0]   strm_len_reg, strm_len_next;
    logic [IDX_W-1:0]   strm_idx_reg, strm_idx_next;
    logic [BYTE_W-1:0]  rdata_reg;
    logic [BYTE_W-1:0]  mem [MEM_DEPTH];
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               mem_we;
    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  out_status_reg, out_status_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;
    logic               load_out;
    logic               out_free;
    logic [CNT_W-1:0]   eff_count;
    logic [LEN_W-1:0]   eff_limit;
    drop_t              drop_cur;
    logic [LEN_W-1:0]   cnt_sat;
    logic [LEN_W-1:0]   get_len;
    logic               strm_last;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                   input logic [CNT_W-1:0] cnt);
        logic [7:0] n;
        n = 8'(s) + 8'd1;
        return (n >= 8'(cnt)) ? '0 : SLOT_W'(n);
    endfunction

    // Out-of-range register values clamp to the legal range.
    always_comb
    begin
        if (cfg_count_reg == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (32'(cfg_count_reg) > SLOTS)
        begin
            eff_count = CNT_W'(SLOTS);
        end
        else
        begin
            eff_count = cfg_count_reg;
        end
        if (cfg_limit_reg == '0)
        begin
            eff_limit = LEN_W'(1);
        end
        else if (32'(cfg_limit_reg) > MSG_BYTES)
        begin
            eff_limit = LEN_W'(MSG_BYTES);
        end
        else
        begin
            eff_limit = LEN_W'(cfg_limit_reg);
        end
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign cnt_sat   = (put_count_reg == '1) ? put_count_reg : put_count_reg + LEN_W'(1);
    assign strm_last = ((LEN_W'(strm_idx_reg) + LEN_W'(1)) == strm_len_reg);
    assign get_len   = (32'(slot_len_reg[read_slot_reg]) > MSG_BYTES) ?
                       LEN_W'(MSG_BYTES) : slot_len_reg[read_slot_reg];

    always_comb
    begin
        state_next      = state_reg;
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        put_count_next  = put_count_reg;
        drop_next       = drop_reg;
        occ_next        = occ_reg;
        len_we          = 1'b0;
        strm_slot_next  = strm_slot_reg;
        strm_len_next   = strm_len_reg;
        strm_idx_next   = strm_idx_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        wr_addr         = {write_slot_reg, put_count_reg[IDX_W-1:0]};
        rd_addr         = {read_slot_reg, IDX_W'(0)};
        load_out        = 1'b0;
        out_status_next = ST_OK;
        out_byte_next   = '0;
        out_last_next   = 1'b1;
        out_len_next    = '0;
        drop_cur        = drop_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    if (head_cmd.kind == CMD_PUT)
                    begin
                        // Fullness is judged once, at the first byte of a message.
                        if (put_count_reg == '0 && drop_reg == DROP_NONE &&
                            occ_reg[write_slot_reg])
                        begin
                            drop_cur = DROP_FULL;
                        end
                        if (drop_cur == DROP_NONE && put_count_reg >= eff_limit)
                        begin
                            drop_cur = DROP_LONG;
                        end
                        if (!head_cmd.last)
                        begin
                            q_pop          = 1'b1;
                            mem_we         = (drop_cur == DROP_NONE);
                            put_count_next = cnt_sat;
                            drop_next      = drop_cur;
                        end
                        else if (out_free)
                        begin
                            q_pop          = 1'b1;
                            mem_we         = (drop_cur == DROP_NONE);
                            load_out       = 1'b1;
                            out_len_next   = cnt_sat;
                            put_count_next = '0;
                            drop_next      = DROP_NONE;
                            case (drop_cur)
                                DROP_FULL:
                                begin
                                    out_status_next = ST_FULL;
                                end
                                DROP_LONG:
                                begin
                                    out_status_next = ST_LONG;
                                end
                                default:
                                begin
                                    out_status_next          = ST_OK;
                                    len_we                   = 1'b1;
                                    occ_next[write_slot_reg] = 1'b1;
                                    write_slot_next = next_slot(write_slot_reg, eff_count);
                                end
                            endcase
                        end
                    end
                    else if (out_free)
                    begin
                        q_pop = 1'b1;
                        if (!occ_reg[read_slot_reg])
                        begin
                            load_out        = 1'b1;
                            out_status_next = ST_EMPTY;
                        end
                        else if (get_len > head_cmd.room)
                        begin
                            load_out        = 1'b1;
                            out_status_next = ST_SMALL;
                            out_len_next    = get_len;
                        end
                        else
                        begin
                            occ_next[read_slot_reg] = 1'b0;
                            read_slot_next = next_slot(read_slot_reg, eff_count);
                            if (get_len == '0)
                            begin
                                load_out = 1'b1;
                            end
                            else
                            begin
                                // First byte read here; rdata_reg has it next cycle.
                                strm_slot_next = read_slot_reg;
                                strm_len_next  = get_len;
                                strm_idx_next  = '0;
                                state_next     = BK_STREAM;
                            end
                        end
                    end
                end
            end
            BK_STREAM:
            begin
                rd_addr = {strm_slot_reg, strm_idx_reg};
                if (out_free)
                begin
                    load_out        = 1'b1;
                    out_status_next = ST_OK;
                    out_byte_next   = rdata_reg;
                    out_last_next   = strm_last;
                    out_len_next    = strm_len_reg;
                    strm_idx_next   = strm_idx_reg + IDX_W'(1);
                    rd_addr         = {strm_slot_reg, strm_idx_next};
                    if (strm_last)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            put_count_reg  <= '0;
            drop_reg       <= DROP_NONE;
            for (int i = 0; i < SLOTS; i++)
            begin
                occ_reg[i] <= 1'b0;
            end
            cfg_count_reg  <= CNT_W'(4);
            cfg_limit_reg  <= CFG_W'(64);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            put_count_reg  <= put_count_next;
            drop_reg       <= drop_next;
            occ_reg        <= occ_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_SLOT_COUNT:
                    begin
                        cfg_count_reg <= cfg_wdata[CNT_W-1:0];
                    end
                    REG_BYTES_LIMIT:
                    begin
                        cfg_limit_reg <= cfg_wdata;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            slot_len_reg[write_slot_reg] <= cnt_sat;
        end
        strm_slot_reg <= strm_slot_next;
        strm_len_reg  <= strm_len_next;
        strm_idx_reg  <= strm_idx_next;
        if (load_out)
        begin
            out_status_reg <= out_status_next;
            out_byte_reg   <= out_byte_next;
            out_last_reg   <= out_last_next;
            out_len_reg    <= out_len_next;
        end
    end

    // Message memory: one write port for puts, one registered read port for gets.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= head_cmd.data;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign bk_stat.streaming = (state_reg == BK_STREAM);
    assign out_valid         = out_valid_reg;
    assign status            = out_status_reg;
    assign out_byte          = out_byte_reg;
    assign out_last          = out_last_reg;
    assign msg_length        = out_len_reg;

endmodule

FILE: rtl/core/message_ring_buffer_unit.sv
// Top level of the message ring buffer unit: front end, command queue and back end.
//
// Input beats arrive on in_valid/in_stall. A put beat (action 0) carries one message
// byte and a last mark; a get beat (action 1) names the receiver room in bytes.
// Result beats leave on out_valid/out_stall with status, out_byte, out_last and
// msg_length. A put beat that is not last gives no result; a last put byte gives one
// result (ok, full or too long). A get gives one empty or too-small result, or one
// result per stored byte with out_last on the final one.
// Put bytes that are not last run at one byte per cycle while the back end is not
// streaming; a last put waits until the output register is free. A get first checks
// the tail slot and starts the memory read, then sends one byte per cycle from the
// single read port while out_stall lets the output register take them.
// A two-entry queue sits between the input register and the back end, so input keeps
// flowing while a result waits in the output register. When out_stall is high the
// output register holds its beat; the back end still stores put bytes that are not
// last but waits with anything that needs a result, and the queue then fills.
// Reset clears the slot occupied marks, the slot pointers, the put state and the
// registers (four slots, 64-byte limit); slot memory is not cleared.
`include "message_ring_buffer_unit_assert.svh"

module message_ring_buffer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [0:0] cfg_addr,
    input  logic [6:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [7:0] put_byte,
    input  logic       put_last,
    input  logic [6:0] get_room,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic [6:0] msg_length
);
    import mrb_pkg::*;

    q_status_t    q_stat;
    logic         q_push;
    logic         q_pop;
    cmd_t         q_push_cmd;
    cmd_t         head_cmd;
    back_status_t bk_stat;

    // The front end registers each beat and turns it into a put or get command.
    mrb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .put_byte   (put_byte),
        .put_last   (put_last),
        .get_room   (get_room),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_push_cmd (q_push_cmd)
    );

    // The queue lets the front end keep accepting while the back end streams.
    mrb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    // The back end owns all ring state and the result register.
    mrb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .q_stat     (q_stat),
        .head_cmd   (head_cmd),
        .q_pop      (q_pop),
        .bk_stat    (bk_stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .msg_length (msg_length)
    );

    // Only a streamed get produces beats without the last mark; they are all ok and
    // the back end is streaming while one waits.
    `MRB_ASSERT_IMPL(a_multi_beat_ok, out_valid && !out_last, status == ST_OK && bk_stat.streaming)
    // An empty report carries no byte and no length.
    `MRB_ASSERT_IMPL(a_empty_clean, out_valid && status == ST_EMPTY, out_byte == '0 && msg_length == '0)
    // After a non-last beat is taken, the next byte of the message follows at once.
    `MRB_ASSERT_NEXT(a_stream_continues, out_valid && !out_stall && !out_last, out_valid)

endmodule

FILE: tb/message_ring_buffer_unit_tb.sv
// Self-checking testbench of the message ring buffer unit, with its own prediction of the ring.
`timescale 1ns / 100ps

module message_ring_buffer_unit_tb;

    import mrb_pkg::*;

    // Cycles allowed for the pipeline to empty after the last expected result.
    // The result path runs through the input register, a two-entry queue and the back end.
    // Put beats that are not last give no result but can still be in flight.
    localparam int LAT_SETTLE     = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [LEN_W-1:0]  len;
    } result_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [0:0]       cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic             action = 1'b0;
    logic [7:0]       put_byte = '0;
    logic             put_last = 1'b0;
    logic [6:0]       get_room = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [2:0]       status;
    logic [7:0]       out_byte;
    logic             out_last;
    logic [6:0]       msg_length;

    message_ring_buffer_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .put_byte   (put_byte),
        .put_last   (put_last),
        .get_room   (get_room),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .msg_length (msg_length)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Commands waiting for the driver, and result beats the ring is known to owe.
    cmd_t    cmd_queue[$];
    result_t expected_results[$];
    int      errors = 0;

    // Shadow copy of the ring: slot bytes, lengths, occupied marks and pointers.
    logic [BYTE_W-1:0] ring_bytes [SLOTS*MSG_BYTES];
    logic [LEN_W-1:0]  ring_len [SLOTS];
    bit                ring_occupied [SLOTS];
    int unsigned       head_slot;
    int unsigned       tail_slot;
    int unsigned       put_seen;
    drop_t             put_drop;
    logic [CNT_W-1:0]  reg_count;
    logic [CFG_W-1:0]  reg_limit;

    // Largest message the current phase accepts, used to shape the traffic.
    int unsigned phase_limit;

    // Driver state.
    cmd_t        offer;
    bit          beat_taken = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    // Receiver state.
    bit          long_hold_due = 1'b0;
    int unsigned hold_left = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_left = 0;
    int unsigned idle_cycles = 0;

    function automatic int unsigned bytes_limit_of(input logic [CFG_W-1:0] value);
        if (32'(value) < 1)
            return 1;
        if (32'(value) > MSG_BYTES)
            return MSG_BYTES;
        return 32'(value);
    endfunction

    // The ring wraps at the slot count in use; 0 behaves as one slot and
    // anything above the built size as the built size.
    function automatic int unsigned next_ring_slot(input int unsigned s);
        int unsigned used;
        used = (32'(reg_count) < 1) ? 1 : (32'(reg_count) > SLOTS) ? SLOTS : 32'(reg_count);
        return (s + 1 >= used) ? 0 : s + 1;
    endfunction

    function automatic void add_expected(input logic [STAT_W-1:0] st,
                                         input logic [BYTE_W-1:0] data,
                                         input logic last, input int unsigned len);
        result_t res;
        res.status = st;
        res.data   = data;
        res.last   = last;
        res.len    = len[LEN_W-1:0];
        expected_results.push_back(res);
    endfunction

    function automatic void reset_ring_shadow();
        foreach (ring_occupied[i])
            ring_occupied[i] = 1'b0;
        head_slot = 0;
        tail_slot = 0;
        put_seen  = 0;
        put_drop  = DROP_NONE;
        reg_count = 3'd4;
        reg_limit = 7'd64;
    endfunction

    function automatic void apply_reg(input logic [0:0] idx, input logic [CFG_W-1:0] value);
        if (idx == REG_SLOT_COUNT)
            reg_count = value[CNT_W-1:0];
        else
            reg_limit = value;
    endfunction

    // Works out the result beats that one accepted command causes.
    function automatic void predict_ring_results(input cmd_t cmd);
        int unsigned w;
        int unsigned r;
        int unsigned len;
        logic [STAT_W-1:0] st;
        if (cmd.kind == CMD_PUT)
        begin
            w = head_slot % SLOTS;
            // Fullness is decided once, at the first byte of a message.
            if (put_seen == 0 && put_drop == DROP_NONE && ring_occupied[SLOT_W'(w)])
                put_drop = DROP_FULL;
            if (put_drop == DROP_NONE)
            begin
                if (put_seen >= bytes_limit_of(reg_limit))
                    put_drop = DROP_LONG;
                else
                    ring_bytes[ADDR_W'(w*MSG_BYTES + put_seen)] = cmd.data;
            end
            if (put_seen < 127)
                put_seen++;
            if (cmd.last)
            begin
                if (put_drop == DROP_FULL)
                    st = ST_FULL;
                else if (put_drop == DROP_LONG)
                    st = ST_LONG;
                else
                begin
                    st = ST_OK;
                    ring_len[SLOT_W'(w)]      = put_seen[LEN_W-1:0];
                    ring_occupied[SLOT_W'(w)] = 1'b1;
                    head_slot                 = next_ring_slot(w);
                end
                add_expected(st, '0, 1'b1, put_seen);
                put_seen = 0;
                put_drop = DROP_NONE;
            end
        end
        else
        begin
            r = tail_slot % SLOTS;
            if (!ring_occupied[SLOT_W'(r)])
                add_expected(ST_EMPTY, '0, 1'b1, 0);
            else
            begin
                len = 32'(ring_len[SLOT_W'(r)]);
                if (len > MSG_BYTES)
                    len = MSG_BYTES;
                if (len > 32'(cmd.room))
                    add_expected(ST_SMALL, '0, 1'b1, len);
                else
                begin
                    ring_occupied[SLOT_W'(r)] = 1'b0;
                    tail_slot                 = next_ring_slot(r);
                    if (len == 0)
                        add_expected(ST_OK, '0, 1'b1, 0);
                    for (int unsigned i = 0; i < len; i++)
                        add_expected(ST_OK, ring_bytes[ADDR_W'(r*MSG_BYTES + i)],
                                     i + 1 == len, len);
                end
            end
        end
    endfunction

    // Input side: a beat is taken at a rising edge with valid high and stall low.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            predict_ring_results(offer);
            beat_taken = 1'b1;
        end
    end

    // Driver: works in bursts with random gaps, and holds a stalled beat unchanged.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || beat_taken)
        begin
            beat_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (cmd_queue.size() > 0)
            begin
                offer = cmd_queue.pop_front();
                in_valid <= 1'b1;
                action   <= offer.kind;
                put_byte <= offer.data;
                put_last <= offer.last;
                get_room <= offer.room;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    // A third of the bursts run straight into the next one.
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: a long hold-off when asked for, otherwise stall patterns that change
    // at random, one of them never stalling at all.
    always @(negedge clk)
    begin
        if (long_hold_due)
        begin
            hold_left     = LONG_HOLD;
            long_hold_due = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(8, 40);
            end
            rx_left--;
            case (rx_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= rx_left[1];
            endcase
        end
    end

    // Monitor: each result beat taken is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result beat with none expected: status %0d byte %0h len %0d",
                         $time, status, out_byte, msg_length);
                errors++;
            end
            else
            begin
                if (status !== expected_results[0].status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, expected_results[0].status, status);
                    errors++;
                end
                if (out_byte !== expected_results[0].data)
                begin
                    $display("%0t: out_byte expected %0h, got %0h",
                             $time, expected_results[0].data, out_byte);
                    errors++;
                end
                if (out_last !== expected_results[0].last)
                begin
                    $display("%0t: out_last expected %0b, got %0b",
                             $time, expected_results[0].last, out_last);
                    errors++;
                end
                if (msg_length !== expected_results[0].len)
                begin
                    $display("%0t: msg_length expected %0d, got %0d",
                             $time, expected_results[0].len, msg_length);
                    errors++;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    // Watchdog: too many cycles in a row without a beat on either side ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic queue_put(input logic [7:0] data, input logic last);
        cmd_t cmd;
        cmd.kind = CMD_PUT;
        cmd.data = data;
        cmd.last = last;
        cmd.room = 7'($urandom_range(0, 127));
        cmd_queue.push_back(cmd);
    endtask

    task automatic queue_get(input logic [6:0] room);
        cmd_t cmd;
        cmd.kind = CMD_GET;
        cmd.data = 8'($urandom_range(0, 255));
        cmd.last = 1'($urandom_range(0, 1));
        cmd.room = room;
        cmd_queue.push_back(cmd);
    endtask

    task automatic queue_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            queue_put(8'($urandom_range(0, 255)), i + 1 == len);
    endtask

    // Mostly whole messages and gets, with some stray bytes and odd rooms mixed in.
    task automatic queue_traffic(input int unsigned n);
        int unsigned added;
        int unsigned pick;
        int unsigned len;
        added = 0;
        while (added < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                len = $urandom_range(0, 9);
                if (len == 0)
                    len = phase_limit + $urandom_range(1, 3);
                else if (len == 1)
                    len = phase_limit;
                else
                    len = $urandom_range(1, (phase_limit < 6) ? phase_limit : 6);
                queue_message(len);
                added += len;
            end
            else if (pick < 85)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    queue_get(7'd0);
                else if (pick == 1)
                    queue_get(7'($urandom_range(65, 127)));
                else if (pick < 5)
                    queue_get(7'($urandom_range(0, 8)));
                else
                    queue_get(7'($urandom_range(0, 64)));
                added++;
            end
            else if (pick < 93)
            begin
                queue_put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                added++;
            end
            else
            begin
                queue_get(7'($urandom_range(0, 127)));
                added++;
            end
        end
    endtask

    // Sender pause: waits until every queued command is taken and every expected
    // result has come out, then lets the pipeline run dry.
    task automatic wait_ring_idle();
        while (cmd_queue.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (LAT_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        @(posedge clk);
        apply_reg(idx, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic start_phase(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] limit);
        wait_ring_idle();
        write_reg(REG_SLOT_COUNT, count);
        write_reg(REG_BYTES_LIMIT, limit);
        phase_limit = bytes_limit_of(limit);
    endtask

    // Register settings of the random phases, raw values that include out-of-range ones.
    logic [CFG_W-1:0] phase_counts [7] = '{7'd1, 7'd127, 7'd2, 7'd0, 7'd3, 7'd5, 7'd4};
    logic [CFG_W-1:0] phase_limits [7] = '{7'd1, 7'd127, 7'd8, 7'd0, 7'd16, 7'd100, 7'd5};

    initial
    begin
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        reset_ring_shadow();
        phase_limit = MSG_BYTES;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset settings of four slots and 64 bytes.
        queue_get(7'd0);                 // empty ring after reset
        queue_put(8'h00, 1'b1);          // one-byte message of all zeros
        queue_put(8'hFF, 1'b0);
        queue_put(8'h80, 1'b0);
        queue_put(8'h7F, 1'b1);
        queue_get(7'd0);                 // room of zero is too small
        queue_get(7'd1);                 // exact fit of the one-byte message
        queue_get(7'd2);                 // one short of the three-byte message
        queue_get(7'd127);               // widest room the field allows
        queue_get(7'd64);                // empty again
        repeat (4) queue_message(1);     // every slot occupied
        queue_put(8'h3C, 1'b0);          // head slot taken, so the whole message drops
        queue_put(8'hC3, 1'b1);
        queue_get(7'd64);
        queue_get(7'd64);

        foreach (phase_counts[i])
        begin
            start_phase(phase_counts[i], phase_limits[i]);
            queue_traffic(5);
        end

        // Pressure: the receiver holds off while the sender keeps offering beats, so
        // the result path and the input queue fill and the input stalls.
        start_phase(7'd4, 7'd64);
        repeat (4) queue_get(7'd64);
        wait_ring_idle();
        long_hold_due = 1'b1;
        repeat (3) queue_message(6);
        repeat (3) queue_get(7'd64);

        // A message past the limit is dropped as too long; the next one fits.
        start_phase(7'd4, 7'd4);
        queue_message(7);
        queue_message(4);
        queue_get(7'd4);

        wait_ring_idle();
        if (errors == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
